// File: src/fat_cluster_table_engine_unit_defines.svh
// Assertion macros used by the cluster table engine top level.
`ifndef FAT_CLUSTER_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FAT_CLUSTER_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside of reset.
`define FCT_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside of reset.
`define FCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/fct_pkg.sv
// Package with the types and constants of the cluster table engine.
`default_nettype none
package fct_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W     = 28;
  localparam int unsigned CLUSTER_W   = 12;
  localparam int unsigned PADDR_W     = 3;

  localparam int unsigned MAX_COUNT = 4094;
  localparam int unsigned SCAN_MAX  =
    (MAX_COUNT < TABLE_DEPTH - 2) ? MAX_COUNT : TABLE_DEPTH - 2;

  localparam logic [CLUSTER_W-1:0] BASE_CLUSTER = 12'd2;
  localparam logic [CLUSTER_W-1:0] COUNT_RESET  = 12'd4094;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_CLUSTER_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_PROBE,
    ST_CHECK,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [TAB_AW-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// File: src/fct_table.sv
// Cluster allocation table memory with its clearing pass after reset.
`default_nettype none
module fct_table
  import fct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mem_req_t           req,
  output logic [ENTRY_W-1:0]      rdata,
  output logic                    ready
);

  // Each entry is stored at the full entry width of ENTRY_W (28) bits.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [TAB_AW-1:0]  clr_addr;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == TAB_AW'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

  assign ready = !clearing;

endmodule
`default_nettype wire

// File: src/fat_cluster_table_engine_unit.sv
// Top level of the cluster allocation table engine.
`default_nettype none
`include "fat_cluster_table_engine_unit_defines.svh"
// After reset the table is cleared one entry per cycle, and no item is
// taken until that pass ends. One item is handled at a time through the
// single table port: a read goes through ST_RD to ST_RESP, a write or an
// unknown command straight to ST_RESP, and an allocate through an ST_PROBE
// and ST_CHECK pair per entry probed (at most cluster_count, capped at
// 4094) before ST_RESP. Each probe is one table read followed by a check
// of the entry, using one shared hint compare-and-advance unit. A finished
// result sits in the output register while the next item is taken.
module fat_cluster_table_engine_unit
  import fct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           command,
  input  wire logic [CLUSTER_W-1:0] cluster,
  input  wire logic [ENTRY_W-1:0]   link_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ENTRY_W-1:0]        result_value,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  st_t                  state, state_next;
  logic [CLUSTER_W-1:0] cluster_count;
  logic [CLUSTER_W-1:0] hint, hint_next;
  logic [CLUSTER_W-1:0] probes, probes_next;
  logic [CLUSTER_W-1:0] probe_q, probe_q_next;
  logic [ENTRY_W-1:0]   result_q, result_q_next;
  logic                 rd_ok, rd_ok_next;
  logic                 out_valid_next;
  logic [ENTRY_W-1:0]   result_value_next;

  mem_req_t             mem_req;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic                 table_ready;

  logic [CLUSTER_W-1:0] scan_n;
  logic [CLUSTER_W:0]   limit;
  logic [CLUSTER_W-1:0] probe;
  logic [CLUSTER_W:0]   probe_inc;
  logic [CLUSTER_W-1:0] hint_adv;
  logic                 in_range;
  logic                 accept;

  fct_table u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .ready (table_ready)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CLUSTER_COUNT) ? 32'(cluster_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_CLUSTER_COUNT) begin
      cluster_count <= pwdata[CLUSTER_W-1:0];
    end
  end

  // Shared hint unit: a stale hint restarts at the first data cluster, and
  // the advanced hint wraps back to it at the end of the scan range.
  assign scan_n    = (32'(cluster_count) > SCAN_MAX) ? CLUSTER_W'(SCAN_MAX)
                                                    : cluster_count;
  assign limit     = {1'b0, scan_n} + (CLUSTER_W + 1)'(BASE_CLUSTER);
  assign probe     = (hint < BASE_CLUSTER || {1'b0, hint} >= limit) ? BASE_CLUSTER
                                                                   : hint;
  assign probe_inc = {1'b0, probe} + 1'b1;
  assign hint_adv  = (probe_inc >= limit) ? BASE_CLUSTER : probe_inc[CLUSTER_W-1:0];

  assign in_range = (32'(cluster) < TABLE_DEPTH);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next        = state;
    hint_next         = hint;
    probes_next       = probes;
    probe_q_next      = probe_q;
    result_q_next     = result_q;
    rd_ok_next        = rd_ok;
    out_valid_next    = out_valid && out_stall;
    result_value_next = result_value;
    mem_req           = '0;

    case (state)
      ST_INIT: begin
        if (table_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_READ: begin
              mem_req.re = 1'b1;
              mem_req.addr = TAB_AW'(cluster);
              rd_ok_next = in_range;
              state_next = ST_RD;
            end
            CMD_WRITE: begin
              mem_req.we    = in_range;
              mem_req.addr  = TAB_AW'(cluster);
              mem_req.wdata = link_value;
              result_q_next = '0;
              state_next    = ST_RESP;
            end
            CMD_ALLOC: begin
              probes_next   = '0;
              result_q_next = '0;
              state_next    = (scan_n == '0) ? ST_RESP : ST_PROBE;
            end
            default: begin
              result_q_next = '0;
              state_next    = ST_RESP;
            end
          endcase
        end
      end
      ST_RD: begin
        result_q_next = rd_ok ? mem_rdata : '0;
        state_next    = ST_RESP;
      end
      ST_PROBE: begin
        mem_req.re   = 1'b1;
        mem_req.addr = TAB_AW'(probe);
        probe_q_next = probe;
        hint_next    = hint_adv;
        probes_next  = probes + 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (mem_rdata == '0) begin
          result_q_next = ENTRY_W'(probe_q);
          state_next    = ST_RESP;
        end else if (probes == scan_n) begin
          result_q_next = '0;
          state_next    = ST_RESP;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          result_value_next = result_q;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      hint      <= BASE_CLUSTER;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hint      <= hint_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    probes       <= probes_next;
    probe_q      <= probe_q_next;
    result_q     <= result_q_next;
    rd_ok        <= rd_ok_next;
    result_value <= result_value_next;
  end

  `FCT_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "item taken while busy")
  `FCT_ASSERT_SAME(a_no_accept_in_clear, !table_ready, in_stall, "item taken during clear")
  `FCT_ASSERT_SAME(a_hint_in_range, state == ST_CHECK, (hint >= BASE_CLUSTER) && ({1'b0, hint} < limit), "hint out of range")
  `FCT_ASSERT_SAME(a_probe_bound, state == ST_CHECK, (probes <= scan_n) && (probes != '0), "probe count beyond scan")

endmodule
`default_nettype wire
